FILE: sv/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and codes for the sorted max-priority queue
// Request and response words, command and status codes, and the
// control and neighbour-link structs used by the cell chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam logic       CMD_INSERT = 1'b0;
   localparam logic       CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam int VALUE_W = 32;
   localparam int FILL_W  = 5;

   typedef struct packed {
      logic                      cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] head_value;
      logic                      is_empty;
      logic [FILL_W-1:0]         fill_count;
      logic [1:0]                status;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic                      ins;
      logic                      rem;
      logic signed [VALUE_W-1:0] new_value;
   } smpq_ctl_type;

   // handed from a cell to the next one down the chain
   typedef struct packed {
      logic                      ge;
      logic signed [VALUE_W-1:0] value;
   } smpq_link_type;

endpackage

FILE: sv/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// Holds one value; on insert it keeps, takes the new value or takes its
// upper neighbour's value; on remove it takes its lower neighbour's value.
// ----------------------------------------------------------------------------
module smpq_cell (
   input  logic                          clock,
   input  smpq_pkg::smpq_ctl_type        ctl,
   input  logic                          occupied,
   input  smpq_pkg::smpq_link_type       up_link,
   input  logic signed [31:0]            down_value,
   output smpq_pkg::smpq_link_type       link,
   output logic signed [31:0]            next_value
);
   import smpq_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      ge;

   // new word belongs at or above this slot
   assign ge = !occupied || (value_ff <= ctl.new_value);

   always_comb begin
      value_in = value_ff;
      if (ctl.ins) begin
         if (up_link.ge) begin
            value_in = up_link.value;
         end else if (ge) begin
            value_in = ctl.new_value;
         end
      end else if (ctl.rem) begin
         value_in = down_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.ge    = ge;
   assign link.value = value_ff;
   assign next_value = value_in;

endmodule

FILE: sv/sorted_max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_top: bounded sorted max-priority queue
// Chain of CAPACITY compare-and-shift cells kept in descending order.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per command, insert a value or remove the head.
//   rsp_ channel: one word per command with the head after the command,
//   the empty flag, the fill count and a status (ok, overflow, underflow).
//   The response is registered at the edge that accepts the command.
//   Every cell compares and shifts in that same cycle, so a command may
//   be accepted in every cycle while the response register is empty or
//   being emptied.
//   If the receiver stalls, the response register holds and req_ready
//   drops until the response is taken; no word is lost.
//   Insert into a full queue is dropped with overflow status; remove on an
//   empty queue leaves it unchanged with underflow status.
//   Reset empties the queue at once (fill count to zero); no clearing pass.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_top #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smpq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output smpq_pkg::rsp_type  rsp_data
);
   import smpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      accept;
   logic                      full;
   logic                      empty;
   smpq_ctl_type              ctl;
   smpq_link_type             links   [CAPACITY];
   logic signed [VALUE_W-1:0] nexts   [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign ctl.ins       = accept && (req_data.cmd == CMD_INSERT) && !full;
   assign ctl.rem       = accept && (req_data.cmd == CMD_REMOVE) && !empty;
   assign ctl.new_value = req_data.value;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         smpq_link_type             up_link;
         logic signed [VALUE_W-1:0] down_value;

         if (gi == 0) begin : g_first
            assign up_link.ge    = 1'b0;
            assign up_link.value = '0;
         end else begin : g_mid
            assign up_link = links[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign down_value = '0;
         end else begin : g_nlast
            assign down_value = links[gi+1].value;
         end

         smpq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (count_ff > CNT_W'(gi)),
            .up_link    (up_link),
            .down_value (down_value),
            .link       (links[gi]),
            .next_value (nexts[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_in            = rsp_ff;
      rsp_in.is_empty   = (count_in == '0);
      rsp_in.head_value = (count_in == '0) ? '0 : nexts[0];
      rsp_in.fill_count = FILL_W'({{FILL_W{1'b0}}, count_in});
      rsp_in.status     = STATUS_OK;
      if (req_data.cmd == CMD_INSERT && full) begin
         rsp_in.status = STATUS_OVERFLOW;
      end else if (req_data.cmd == CMD_REMOVE && empty) begin
         rsp_in.status = STATUS_UNDERFLOW;
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
